// ===== hdl/adsr_env_pkg.sv =====
// Shared constants and the fraction table function of the ADSR envelope generator.
package adsr_env_pkg;

    localparam int FRACTION_TABLE_SIZE_DEFAULT = 256;

    localparam logic [31:0] BASE_COEF_RESET = 32'd549032;

    localparam logic [1:0] PH_RELEASE = 2'd0;
    localparam logic [1:0] PH_ATTACK  = 2'd1;
    localparam logic [1:0] PH_DECAY   = 2'd2;

    localparam logic signed [31:0] ATTACK_TARGET   = 32'sd1181116032;
    localparam logic signed [31:0] DECAY_THRESHOLD = 32'sd1063004405;
    localparam logic signed [15:0] GATE_HALF       = 16'sd16384;
    localparam logic [63:0]        LN2_Q30         = 64'd744261118;
    localparam int                 TAYLOR_TERMS    = 12;

    localparam int MUL_WIDTH  = 32;
    localparam int MUL_DIGITS = MUL_WIDTH / 2;

    // Integer Taylor sum of exp(w) with w in Q2.30; gives 2^(k/N) in Q1.30.
    function automatic logic [31:0] frac_entry(input logic [63:0] w);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = term;
        for (int i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term = ((term * w) >> 30) / 64'(i);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

// ===== hdl/adsr_envelope_one_pole_top.sv =====
// ADSR envelope generator with a one-pole smoothing filter, top level.
//
// One input word per sample tick arrives on the s_ channel: gate, attack time,
// decay time, sustain level and release time, all Q1.15. For every accepted
// word exactly one result word leaves on the m_ channel: the new envelope
// value in Q2.14 and the phase after the step (0 release, 1 attack, 2 decay).
// The block works on one word at a time. An accepted word passes the setup,
// fetch, prepare, multiply, scale, prepare, multiply and finish states, and
// the next word is taken back in idle. Two radix-4 multiplies of 16 steps
// each run in turn: the coefficient scaling and the filter update share one
// multiplier. The result sits in an output register, so a new word is taken
// while the previous result still waits; a stalled receiver only holds the
// block once the following result is ready to be written.
// Reset: release phase, zero filter value, default base coefficient loaded.
// cfg_wr_en writes cfg_wr_data into the base coefficient register at once;
// the user must write it only while the block is idle; it is not enforced.
module adsr_envelope_one_pole_top #(
    parameter int FRACTION_TABLE_SIZE = adsr_env_pkg::FRACTION_TABLE_SIZE_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gate, attack_time, decay_time, sustain_level, release_time
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // envelope, phase, zero fill
    output logic [23:0] m_tdata
);
    import adsr_env_pkg::*;

    localparam int IDXW = $clog2(FRACTION_TABLE_SIZE);
    localparam int FPW  = 15 + IDXW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FETCH,
        ST_PREP1,
        ST_MUL1,
        ST_SCALE,
        ST_PREP2,
        ST_MUL2,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [3:0]         cnt_reg;
    logic [1:0]         phase_reg;
    logic signed [31:0] filter_reg;
    logic [31:0]        base_reg;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;

    logic signed [31:0] target_reg;
    logic signed [15:0] time_reg;
    logic [1:0]         new_phase_reg;
    logic [32:0]        diff_reg;
    logic [31:0]        mag_reg;
    logic [IDXW-1:0]    idx_reg;
    logic [5:0]         shift_reg;
    logic [31:0]        ma_reg;
    logic [33:0]        a3_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        mq_reg;
    logic               coef_one_reg;

    logic [31:0] frac_rom [FRACTION_TABLE_SIZE];

    for (genvar k = 0; k < FRACTION_TABLE_SIZE; k++)
    begin : g_rom
        localparam logic [63:0] W = (LN2_Q30 * 64'(k)) / 64'(FRACTION_TABLE_SIZE);
        assign frac_rom[k] = frac_entry(W);
    end

    logic signed [15:0] in_gate;
    logic signed [15:0] in_attack;
    logic signed [15:0] in_decay;
    logic signed [15:0] in_sustain;
    logic signed [15:0] in_release;
    logic signed [31:0] target_next;
    logic signed [15:0] time_next;
    logic [1:0]         phase_next;

    assign in_gate    = s_tdata[15:0];
    assign in_attack  = s_tdata[31:16];
    assign in_decay   = s_tdata[47:32];
    assign in_sustain = s_tdata[63:48];
    assign in_release = s_tdata[79:64];

    always_comb
    begin
        case (phase_reg)
            PH_ATTACK:
            begin
                target_next = ATTACK_TARGET;
                time_next   = in_attack;
                if (filter_reg > DECAY_THRESHOLD)
                    phase_next = PH_DECAY;
                else if (in_gate < GATE_HALF)
                    phase_next = PH_RELEASE;
                else
                    phase_next = PH_ATTACK;
            end
            PH_DECAY:
            begin
                target_next = {in_sustain[15], in_sustain, 15'd0};
                time_next   = in_decay;
                phase_next  = (in_gate < GATE_HALF) ? PH_RELEASE : PH_DECAY;
            end
            default:
            begin
                target_next = '0;
                time_next   = in_release;
                phase_next  = (in_gate > GATE_HALF) ? PH_ATTACK : PH_RELEASE;
            end
        endcase
    end

    logic signed [20:0] time_ext;
    logic signed [20:0] xs_next;
    logic [FPW-1:0]     fprod_next;
    logic [5:0]         shift_next;
    logic [32:0]        diff_next;
    logic [31:0]        mag_next;

    assign time_ext   = {{5{time_reg[15]}}, time_reg};
    assign xs_next    = 21'sd327680 - (time_ext <<< 3) - (time_ext <<< 1);
    assign fprod_next = FPW'(xs_next[14:0]) * FPW'(FRACTION_TABLE_SIZE);
    assign shift_next = 6'd40 - {1'b0, xs_next[19:15]};
    assign diff_next  = {target_reg[31], target_reg} - {filter_reg[31], filter_reg};
    assign mag_next   = diff_reg[32] ? 32'(33'd0 - diff_reg) : diff_reg[31:0];

    logic [33:0] pp_next;
    logic [33:0] sum_next;

    always_comb
    begin
        case (mq_reg[1:0])
            2'd0:    pp_next = '0;
            2'd1:    pp_next = {2'b00, ma_reg};
            2'd2:    pp_next = {1'b0, ma_reg, 1'b0};
            default: pp_next = a3_reg;
        endcase
    end

    assign sum_next = {2'b00, acc_reg} + pp_next;

    logic [63:0] prod_next;
    logic [63:0] scaled_next;

    assign prod_next   = {acc_reg, mq_reg};
    assign scaled_next = prod_next >> shift_reg;

    logic [31:0] step_next;
    logic [32:0] nz_wide;
    logic [31:0] nz_next;

    assign step_next = coef_one_reg ? mag_reg : acc_reg;
    assign nz_wide   = diff_reg[32] ? ({filter_reg[31], filter_reg} - {1'b0, step_next})
                                    : ({filter_reg[31], filter_reg} + {1'b0, step_next});

    always_comb
    begin
        if (nz_wide[32] != nz_wide[31])
            nz_next = nz_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            nz_next = nz_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= PH_RELEASE;
            filter_reg   <= '0;
            base_reg     <= BASE_COEF_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                    state_reg <= ST_FETCH;
                ST_FETCH:
                    state_reg <= ST_PREP1;
                ST_PREP1:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(MUL_DIGITS - 1))
                        state_reg <= ST_SCALE;
                end
                ST_SCALE:
                    state_reg <= ST_PREP2;
                ST_PREP2:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(MUL_DIGITS - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        filter_reg   <= nz_next;
                        phase_reg    <= new_phase_reg;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, new_phase_reg, nz_next[31:16]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                target_reg    <= target_next;
                time_reg      <= time_next;
                new_phase_reg <= phase_next;
            end
            ST_SETUP:
            begin
                idx_reg   <= fprod_next[15 +: IDXW];
                shift_reg <= shift_next;
                diff_reg  <= diff_next;
            end
            ST_FETCH:
            begin
                mq_reg  <= frac_rom[idx_reg];
                ma_reg  <= base_reg;
                mag_reg <= mag_next;
            end
            ST_PREP1, ST_PREP2:
            begin
                a3_reg  <= {2'b00, ma_reg} + {1'b0, ma_reg, 1'b0};
                acc_reg <= '0;
            end
            ST_MUL1, ST_MUL2:
            begin
                acc_reg <= sum_next[33:2];
                mq_reg  <= {sum_next[1:0], mq_reg[31:2]};
            end
            ST_SCALE:
            begin
                ma_reg       <= scaled_next[31:0];
                coef_one_reg <= scaled_next[63:32] != 32'd0;
                mq_reg       <= mag_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
